// ===== src/aars_pkg.sv =====
// ---------------------------------------------------------------------------
// aars_pkg: shared constants and types for the auto-ranging scaler
// Holds the fixed field widths, reset values and the command bundle that
// passes from the controller to the datapath.
// ---------------------------------------------------------------------------
package aars_pkg;

    // Fixed widths of the port fields
    localparam int RAW_W   = 10;
    localparam int SCALE_W = 8;
    localparam int POS_W   = 8;

    // Default sample width used by the datapath
    localparam int SAMPLE_BITS_DEF = 10;

    // Reset value of the full-scale register
    localparam logic [SCALE_W-1:0] FULL_SCALE_RESET = 8'd48;

    // One quotient bit per divide step; the quotient never exceeds full scale
    localparam int DIV_STEPS = POS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cfg_wr;    // write full-scale register
        logic load;      // take a sample word, widen the tracked range
        logic mul;       // form offset * full scale and the span
        logic div_step;  // one restoring divide step
        logic out_load;  // move the quotient into the output register
    } aars_cmd_t;

endpackage

// ===== src/adc_autorange_scaler_unit.sv =====
// ---------------------------------------------------------------------------
// adc_autorange_scaler_unit: auto-ranging converter sample scaler
// Tracks the running min and max of the samples and reports each sample's
// position (sample - min) * full_scale / (max - min) within that range.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    raw_sample
//   out      output     out_valid / out_ready  position, range_zero
//   cfg      input      cfg_valid / cfg_ready  cfg_data (full_scale)
//
// The accepting edge also widens the range; then come the product, 8 restoring
// divide steps and the output load, which raises out_valid.
// The divider forms one quotient bit per cycle, and one word is in work at once.
// A new word is taken while the previous result waits in the output register;
// the output load stalls until that register is free.
// Reset restores full_scale to 48 and both tracked limits to mid-scale.
// ---------------------------------------------------------------------------
module adc_autorange_scaler_unit
#(
    parameter int SAMPLE_BITS = aars_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [aars_pkg::RAW_W-1:0]   raw_sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [aars_pkg::POS_W-1:0]   position,
    output logic                         range_zero,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [aars_pkg::SCALE_W-1:0] cfg_data
);
    import aars_pkg::*;

    aars_cmd_t cmd;

    // Sequencing controller
    aars_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // Tracking and divide datapath
    aars_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .raw_sample (raw_sample),
        .cfg_data   (cfg_data),
        .position   (position),
        .range_zero (range_zero)
    );

    // An empty range always reports position 0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_zero |-> position == '0)
        else $error("empty range with nonzero position");

    // Only one word is in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while busy");

    // A result never overwrites one that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid || out_ready)
        else $error("output register overwritten");

    // No two of load, product, divide step and output load issue together
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.div_step, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

// ===== src/aars_ctrl.sv =====
// ---------------------------------------------------------------------------
// aars_ctrl: sequencing controller
// Steps one sample word through product, divide and output load, and owns
// the handshake on all three channels.
// ---------------------------------------------------------------------------
module aars_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    output aars_pkg::aars_cmd_t cmd
);
    import aars_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Next state, step count and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.cfg_wr     = cfg_valid;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/aars_dp.sv =====
// ---------------------------------------------------------------------------
// aars_dp: tracking and scaling datapath
// Keeps the running min and max, forms the scaled offset and divides it by
// the span with a restoring divider, one quotient bit per step.
// ---------------------------------------------------------------------------
module aars_dp
#(
    parameter int SAMPLE_BITS = aars_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  aars_pkg::aars_cmd_t               cmd,
    input  logic [aars_pkg::RAW_W-1:0]        raw_sample,
    input  logic [aars_pkg::SCALE_W-1:0]      cfg_data,
    output logic [aars_pkg::POS_W-1:0]        position,
    output logic                              range_zero
);
    import aars_pkg::*;

    localparam int EXT_W  = (SAMPLE_BITS > RAW_W) ? SAMPLE_BITS : RAW_W;
    localparam int PROD_W = SAMPLE_BITS + SCALE_W;
    localparam logic [SAMPLE_BITS-1:0] MID_SCALE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic [EXT_W-1:0]       raw_ext;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SCALE_W-1:0]     scale_reg;
    logic [SAMPLE_BITS-1:0] span;
    logic [SAMPLE_BITS-1:0] offset;
    logic [PROD_W-1:0]      rem_reg;
    logic [PROD_W-1:0]      dvs_reg;
    logic [POS_W-1:0]       quo_reg;
    logic                   zero_reg;
    logic                   fits;
    logic [POS_W-1:0]       pos_reg;
    logic                   range_zero_reg;

    // Keep the low sample bits of the converter word
    assign raw_ext   = EXT_W'(raw_sample);
    assign sample_in = raw_ext[SAMPLE_BITS-1:0];

    // Widen the tracked range with the new sample
    assign min_next = (sample_in < min_reg) ? sample_in : min_reg;
    assign max_next = (sample_in > max_reg) ? sample_in : max_reg;

    assign span   = max_reg - min_reg;
    assign offset = sample_reg - min_reg;
    assign fits   = (rem_reg >= dvs_reg);

    // Full-scale register and tracked range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= FULL_SCALE_RESET;
            min_reg   <= MID_SCALE;
            max_reg   <= MID_SCALE;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                scale_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                min_reg <= min_next;
                max_reg <= max_next;
            end
        end
    end

    // Product, divider and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.mul)
        begin
            rem_reg  <= PROD_W'(offset) * PROD_W'(scale_reg);
            // Align the divisor with the top quotient bit
            dvs_reg  <= PROD_W'(span) << (POS_W - 1);
            zero_reg <= (span == '0);
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            quo_reg <= {quo_reg[POS_W-2:0], fits};
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.out_load)
        begin
            // Empty range: report position 0 and flag it
            pos_reg        <= zero_reg ? '0 : quo_reg;
            range_zero_reg <= zero_reg;
        end
    end

    assign position   = pos_reg;
    assign range_zero = range_zero_reg;

endmodule

// ===== bench/adc_autorange_scaler_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_autorange_scaler_unit_tb: self-checking bench for the auto-ranging scaler
// Sends converter sample words through the input channel, predicts the
// tracked min/max and the scaled position of each word, and checks every
// output word against the oldest prediction. Runs directed cases (empty
// range, one-step spans, full scale 0 and 1, field extremes, output
// back-pressure) and slow random range growth under several full-scale
// settings, with random idle bursts on both sides.
// ---------------------------------------------------------------------------
module adc_autorange_scaler_unit_tb;

    import aars_pkg::*;

    localparam int SAMPLE_BITS    = SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int MID_SCALE      = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_SETTLE     = 40;
    localparam int GROWTH_PHASES  = 6;
    localparam int GROWTH_WORDS   = 280;

    // One output word as the block reports it
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             range_zero;
    } scaled_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [RAW_W-1:0]     raw_sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [POS_W-1:0]     position;
    logic                 range_zero;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [SCALE_W-1:0]   cfg_data;

    // Predicted state of the block
    logic [SCALE_W-1:0]     full_scale_cfg;
    logic [SAMPLE_BITS-1:0] range_lo;
    logic [SAMPLE_BITS-1:0] range_hi;
    scaled_word_t           pending_positions[$];

    int unsigned error_count;
    int unsigned stall_cycles;
    logic        tx_idle_en;
    logic        rx_idle_en;
    logic        hold_req;

    adc_autorange_scaler_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .range_zero (range_zero),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Widen the tracked range with one sample and scale it into 0..full scale
    function automatic scaled_word_t predict_position(input logic [RAW_W-1:0] raw);
        logic [SAMPLE_BITS-1:0] smp;
        int unsigned            span;
        int unsigned            product;
        scaled_word_t           word;
        smp = raw[SAMPLE_BITS-1:0];
        if (smp < range_lo)
            range_lo = smp;
        if (smp > range_hi)
            range_hi = smp;
        span = int'(range_hi) - int'(range_lo);
        word.range_zero = (span == 0);
        if (span == 0)
        begin
            word.position = '0;
        end
        else
        begin
            product       = (int'(smp) - int'(range_lo)) * int'(full_scale_cfg);
            word.position = POS_W'(product / span);
        end
        return word;
    endfunction

    // Offer one sample word, optionally after an idle burst, and hold it until taken
    task automatic send_sample(input logic [RAW_W-1:0] smp);
        logic taken;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        raw_sample <= smp;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        pending_positions.push_back(predict_position(smp));
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic wait_drained(input int unsigned settle);
        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write the full-scale register; only called while the block is idle
    task automatic write_full_scale(input logic [SCALE_W-1:0] value);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid      <= 1'b0;
        full_scale_cfg  = value;
        @(posedge clk);
    endtask

    // Mid-scale samples right after reset leave max equal to min
    task automatic test_empty_range();
        send_sample(RAW_W'(MID_SCALE));
        send_sample(RAW_W'(MID_SCALE));
        wait_drained(4);
    endtask

    // Spans of one to four steps at the widest full scale
    task automatic test_narrow_span();
        write_full_scale(8'd255);
        send_sample(RAW_W'(MID_SCALE + 1));
        send_sample(RAW_W'(MID_SCALE));
        send_sample(RAW_W'(MID_SCALE - 1));
        send_sample(RAW_W'(MID_SCALE));
        send_sample(RAW_W'(MID_SCALE + 1));
        send_sample(RAW_W'(MID_SCALE - 2));
        send_sample(RAW_W'(MID_SCALE + 2));
        wait_drained(4);
    endtask

    // Full scale of zero forces every position to zero
    task automatic test_full_scale_zero();
        write_full_scale(8'd0);
        send_sample(RAW_W'(MID_SCALE - 3));
        send_sample(RAW_W'(MID_SCALE));
        send_sample(RAW_W'(MID_SCALE + 3));
        send_sample(RAW_W'(MID_SCALE - 11));
        wait_drained(4);
    endtask

    // Full scale of one: only the maximum reaches one
    task automatic test_full_scale_one();
        write_full_scale(8'd1);
        send_sample(RAW_W'(MID_SCALE + 3));
        send_sample(RAW_W'(MID_SCALE - 12));
        send_sample(RAW_W'(MID_SCALE + 9));
        send_sample(RAW_W'(MID_SCALE - 14));
        wait_drained(4);
    endtask

    // Grow the tracked range slowly so many divisor values get exercised
    task automatic test_random_growth();
        int unsigned            pick;
        int unsigned            room;
        int unsigned            lo;
        int unsigned            hi;
        logic [RAW_W-1:0]       smp;
        logic [SCALE_W-1:0]     scale;
        for (int phase = 0; phase < GROWTH_PHASES; phase++)
        begin
            unique case (phase)
                0:       scale = 8'd255;
                1:       scale = 8'd0;
                2:       scale = 8'd1;
                default: scale = SCALE_W'($urandom_range(2, 254));
            endcase
            write_full_scale(scale);
            // one phase runs with no idling at all
            tx_idle_en = (phase != 4);
            rx_idle_en = (phase != 4);
            repeat (GROWTH_WORDS)
            begin
                lo   = range_lo;
                hi   = range_hi;
                pick = $urandom_range(0, 99);
                if (pick < 6 && lo > 0)
                begin
                    room = (lo < 4) ? lo : 4;
                    smp  = RAW_W'(lo - $urandom_range(1, room));
                end
                else if (pick < 12 && hi < SAMPLE_MAX)
                begin
                    room = (SAMPLE_MAX - hi < 4) ? SAMPLE_MAX - hi : 4;
                    smp  = RAW_W'(hi + $urandom_range(1, room));
                end
                else if (pick < 24)
                    smp = RAW_W'(lo);
                else if (pick < 36)
                    smp = RAW_W'(hi);
                else
                    smp = RAW_W'($urandom_range(lo, hi));
                send_sample(smp);
            end
            wait_drained(4);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Both ends of the sample field and alternating bit patterns
    task automatic test_field_extremes();
        write_full_scale(8'd255);
        send_sample('0);
        send_sample('1);
        send_sample('0);
        send_sample('1);
        send_sample(10'h155);
        send_sample(10'h2AA);
        send_sample(10'h001);
        send_sample(10'h3FE);
        wait_drained(4);
    endtask

    // Hold off the receiver while words keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_full_scale(SCALE_W'($urandom_range(2, 254)));
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (8) send_sample(RAW_W'($urandom_range(0, SAMPLE_MAX)));
        tx_idle_en = 1'b1;
        wait_drained(4);
    endtask

    // Full-range random words with no idling on either side
    task automatic test_final_stretch();
        write_full_scale(FULL_SCALE_RESET);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (200) send_sample(RAW_W'($urandom_range(0, SAMPLE_MAX)));
    endtask

    // Drive the output ready: random stall bursts and one long hold-off
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each output word taken at the coming edge with the oldest prediction
    always @(negedge clk)
    begin : check_output
        scaled_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_positions.size() == 0)
            begin
                $display("%0t: unexpected word position=%0d range_zero=%0d",
                         $time, position, range_zero);
                error_count++;
            end
            else
            begin
                want = pending_positions.pop_front();
                if (want.position !== position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, position);
                    error_count++;
                end
                if (want.range_zero !== range_zero)
                begin
                    $display("%0t: range_zero expected %0d actual %0d",
                             $time, want.range_zero, range_zero);
                    error_count++;
                end
            end
        end
    end

    // End the run if no word moves on any channel for too long
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        raw_sample     = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        error_count    = 0;
        stall_cycles   = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        hold_req       = 1'b0;
        full_scale_cfg = FULL_SCALE_RESET;
        range_lo       = SAMPLE_BITS'(MID_SCALE);
        range_hi       = SAMPLE_BITS'(MID_SCALE);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_range();
        test_narrow_span();
        test_full_scale_zero();
        test_full_scale_one();
        test_random_growth();
        test_field_extremes();
        test_output_backpressure();
        test_final_stretch();

        wait_drained(END_SETTLE);
        if (error_count == 0 && pending_positions.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== adc_autorange_scaler_unit.f =====
src/aars_pkg.sv
src/aars_ctrl.sv
src/aars_dp.sv
src/adc_autorange_scaler_unit.sv
bench/adc_autorange_scaler_unit_tb.sv
